// File: rtl/drt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS record TTL refresh timer - shared definitions
// Widths, opcodes, status codes, the per-mille schedule table and the
// structure that carries a prepared item from the prep stage to the core.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int TIME_BITS = 56;   // internal time width, microseconds
  localparam int NOW_W     = 56;   // width of the now_time port
  localparam int TTL_W     = 32;
  localparam int JIT_W     = 5;
  localparam int IDX_W     = 3;
  localparam int PM_W      = 10;   // per-mille value plus jitter, up to 1000
  localparam int MS_W      = 42;   // ttl * 1000
  localparam int US_W      = 52;   // ttl * 1000000
  localparam int CMP_W     = (TIME_BITS > US_W) ? TIME_BITS : US_W;

  localparam logic [JIT_W-1:0] JITTER_MAX = 5'd20;
  localparam logic [IDX_W-1:0] LAST_POINT = 3'd4;
  localparam logic [IDX_W-1:0] IDX_SAT    = 3'd5;
  localparam logic [9:0]       MS_PER_S   = 10'd1000;
  localparam logic [19:0]      US_PER_S   = 20'd1000000;

  typedef enum logic [1:0] {
    OP_LOAD        = 2'd0,
    OP_UPDATE      = 2'd1,
    OP_EXPIRE_SOON = 2'd2,
    OP_TICK        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_INVALID  = 3'd1,
    ST_GOODBYE  = 3'd2,
    ST_TTL_ONLY = 3'd3,
    ST_NEW_DATA = 3'd4
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [TIME_BITS-1:0] now;
    logic [MS_W-1:0]      ttl_ms;
    logic [US_W-1:0]      ttl_us;
    logic [US_W-1:0]      half_us;
    logic                 ttl_zero;
    logic                 key_matches;
    logic                 same_rdata;
    logic [JIT_W-1:0]     jitter;
  } prep_t;

  function automatic logic [PM_W-1:0] point_permille(input logic [IDX_W-1:0] idx);
    logic [PM_W-1:0] pm;
    case (idx)
      3'd0:    pm = 10'd800;
      3'd1:    pm = 10'd850;
      3'd2:    pm = 10'd900;
      3'd3:    pm = 10'd950;
      default: pm = 10'd1000;
    endcase
    return pm;
  endfunction

endpackage
`default_nettype wire

// File: rtl/drt_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS record TTL refresh timer - input and prep stages
// Registers the arriving item, then forms the TTL products in milliseconds,
// microseconds and half-TTL microseconds, and saturates the jitter.
// ----------------------------------------------------------------------------
module drt_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [drt_pkg::NOW_W-1:0]  now_time_i,
  input  logic [drt_pkg::TTL_W-1:0]  ttl_seconds_i,
  input  logic                       key_matches_i,
  input  logic                       same_rdata_i,
  input  logic [drt_pkg::JIT_W-1:0]  jitter_permille_i,
  input  logic                       core_ready_i,
  output logic                       prep_valid_o,
  output drt_pkg::prep_t             prep_o
);

  logic                          s1_valid_q;
  drt_pkg::op_e                  s1_op_q;
  logic [drt_pkg::TIME_BITS-1:0] s1_now_q;
  logic [drt_pkg::TTL_W-1:0]     s1_ttl_q;
  logic                          s1_key_q;
  logic                          s1_same_q;
  logic [drt_pkg::JIT_W-1:0]     s1_jit_q;

  logic                          s2_valid_q;
  drt_pkg::prep_t                s2_q;
  drt_pkg::prep_t                s2_d;

  logic s1_free;
  logic s2_free;

  assign s2_free    = !s2_valid_q || core_ready_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_op_q   <= drt_pkg::op_e'(opcode_i);
      s1_now_q  <= drt_pkg::TIME_BITS'(now_time_i);
      s1_ttl_q  <= ttl_seconds_i;
      s1_key_q  <= key_matches_i;
      s1_same_q <= same_rdata_i;
      s1_jit_q  <= jitter_permille_i;
    end
    if (s1_valid_q && s2_free) begin
      s2_q <= s2_d;
    end
  end

  always_comb begin
    s2_d             = '0;
    s2_d.op          = s1_op_q;
    s2_d.now         = s1_now_q;
    s2_d.ttl_ms      = drt_pkg::MS_W'(s1_ttl_q) * drt_pkg::MS_W'(drt_pkg::MS_PER_S);
    s2_d.ttl_us      = drt_pkg::US_W'(s1_ttl_q) * drt_pkg::US_W'(drt_pkg::US_PER_S);
    // half TTL in whole seconds
    s2_d.half_us     = drt_pkg::US_W'(s1_ttl_q[drt_pkg::TTL_W-1:1])
                       * drt_pkg::US_W'(drt_pkg::US_PER_S);
    s2_d.ttl_zero    = (s1_ttl_q == '0);
    s2_d.key_matches = s1_key_q;
    s2_d.same_rdata  = s1_same_q;
    s2_d.jitter      = (s1_jit_q > drt_pkg::JITTER_MAX) ? drt_pkg::JITTER_MAX : s1_jit_q;
  end

  assign prep_valid_o = s2_valid_q;
  assign prep_o       = s2_q;

endmodule
`default_nettype wire

// File: rtl/drt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS record TTL refresh timer - record state and result register
// Holds the cached record, decides each event, computes the
// next send offset from the start time and registers the result item.
// ----------------------------------------------------------------------------
module drt_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           prep_valid_i,
  input  drt_pkg::prep_t prep_i,
  output logic           core_ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     status_o,
  output logic           send_query_o,
  output logic           expired_o,
  output logic           nearing_expiry_o
);

  // record state; due_q is the next send time relative to start_q
  logic                          valid_q;
  logic                          armed_q;
  logic [drt_pkg::IDX_W-1:0]     idx_q;
  logic [drt_pkg::TIME_BITS-1:0] start_q;
  logic [drt_pkg::TIME_BITS-1:0] due_q;
  logic [drt_pkg::MS_W-1:0]      ttl_ms_q;
  logic [drt_pkg::US_W-1:0]      ttl_us_q;
  logic [drt_pkg::US_W-1:0]      half_us_q;

  logic                          out_valid_q;
  drt_pkg::status_e              status_q;
  logic                          send_q;
  logic                          expired_q;
  logic                          nearing_q;

  logic                          out_free;
  logic                          fire;
  logic [drt_pkg::TIME_BITS-1:0] elapsed;
  logic                          restart;
  logic                          short_ttl;
  logic                          tick_send;
  logic                          drop;
  drt_pkg::status_e              status_d;
  logic [drt_pkg::MS_W-1:0]      sched_ms;
  logic [drt_pkg::IDX_W-1:0]     sched_idx;
  logic [drt_pkg::IDX_W-1:0]     pt_idx;
  logic [drt_pkg::PM_W-1:0]      pm;
  logic [drt_pkg::TIME_BITS-1:0] due_d;
  logic [drt_pkg::IDX_W-1:0]     idx_d;
  logic                          valid_d;
  logic                          nearing_d;
  logic [drt_pkg::US_W-1:0]      new_us;
  logic [drt_pkg::US_W-1:0]      new_half;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign core_ready_o = out_free;
  assign fire         = prep_valid_i && out_free;

  assign elapsed = prep_i.now - start_q;

  always_comb begin
    restart   = 1'b0;
    short_ttl = 1'b0;
    tick_send = 1'b0;
    drop      = 1'b0;
    status_d  = drt_pkg::ST_NONE;
    unique case (prep_i.op)
      drt_pkg::OP_LOAD: begin
        restart = 1'b1;
      end
      drt_pkg::OP_UPDATE: begin
        if (!valid_q || !prep_i.key_matches || (prep_i.ttl_zero && !prep_i.same_rdata)) begin
          status_d = drt_pkg::ST_INVALID;
        end else if (prep_i.ttl_zero) begin
          status_d  = drt_pkg::ST_GOODBYE;
          restart   = 1'b1;
          short_ttl = 1'b1;
        end else begin
          status_d = prep_i.same_rdata ? drt_pkg::ST_TTL_ONLY : drt_pkg::ST_NEW_DATA;
          restart  = 1'b1;
        end
      end
      drt_pkg::OP_EXPIRE_SOON: begin
        if (valid_q) begin
          restart   = 1'b1;
          short_ttl = 1'b1;
        end
      end
      drt_pkg::OP_TICK: begin
        if (valid_q && armed_q && (elapsed >= due_q)) begin
          if (drt_pkg::CMP_W'(elapsed) >= drt_pkg::CMP_W'(ttl_us_q)) begin
            drop = 1'b1;
          end else begin
            tick_send = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // schedule from the restarted record or from the stored one
    if (restart) begin
      sched_ms  = short_ttl ? drt_pkg::MS_W'(drt_pkg::MS_PER_S) : prep_i.ttl_ms;
      sched_idx = short_ttl ? drt_pkg::LAST_POINT : '0;
    end else begin
      sched_ms  = ttl_ms_q;
      sched_idx = idx_q;
    end
    new_us   = short_ttl ? drt_pkg::US_W'(drt_pkg::US_PER_S) : prep_i.ttl_us;
    new_half = short_ttl ? '0 : prep_i.half_us;

    pt_idx = (sched_idx > drt_pkg::LAST_POINT) ? drt_pkg::LAST_POINT : sched_idx;
    pm     = drt_pkg::point_permille(pt_idx)
             + ((pt_idx < drt_pkg::LAST_POINT) ? drt_pkg::PM_W'(prep_i.jitter) : '0);
    due_d  = drt_pkg::TIME_BITS'(drt_pkg::US_W'(sched_ms) * drt_pkg::US_W'(pm));
    idx_d  = (sched_idx < drt_pkg::IDX_SAT) ? sched_idx + 1'b1 : sched_idx;

    valid_d   = restart ? 1'b1 : (drop ? 1'b0 : valid_q);
    // a restart leaves zero elapsed time, which is never past half the TTL
    nearing_d = valid_d && !restart
                && (drt_pkg::CMP_W'(elapsed) > drt_pkg::CMP_W'(half_us_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      armed_q   <= 1'b0;
      idx_q     <= '0;
      start_q   <= '0;
      due_q     <= '0;
      ttl_ms_q  <= '0;
      ttl_us_q  <= '0;
      half_us_q <= '0;
    end else if (fire) begin
      valid_q <= valid_d;
      if (restart || tick_send) begin
        due_q   <= due_d;
        idx_q   <= idx_d;
        armed_q <= 1'b1;
      end else if (drop) begin
        armed_q <= 1'b0;
      end
      if (restart) begin
        start_q   <= prep_i.now;
        ttl_ms_q  <= sched_ms;
        ttl_us_q  <= new_us;
        half_us_q <= new_half;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= prep_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      send_q    <= tick_send;
      expired_q <= drop;
      nearing_q <= nearing_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign send_query_o     = send_q;
  assign expired_o        = expired_q;
  assign nearing_expiry_o = nearing_q;

endmodule
`default_nettype wire

// File: rtl/dns_record_ttl_refresh_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// DNS record TTL refresh timer
// Tracks one cached DNS record and schedules refresh queries and expiry.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output is not stalled and returns one result
// item for each, through these stages in turn: an input register, a stage
// that forms the TTL products, and the record update that writes the result
// register. The record state sits in that last stage, so every item sees the
// state left by the one before it with no wait; that stage holds a single
// 42 by 10 bit multiply for the next send offset. Refresh queries fall at 80,
// 85, 90 and 95 percent of the TTL plus the jitter in per-mille (capped at 20),
// expiry at 100 percent; all times are microseconds.
module dns_record_ttl_refresh_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [drt_pkg::NOW_W-1:0]  now_time_i,
  input  logic [drt_pkg::TTL_W-1:0]  ttl_seconds_i,
  input  logic                       key_matches_i,
  input  logic                       same_rdata_i,
  input  logic [drt_pkg::JIT_W-1:0]  jitter_permille_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic                       send_query_o,
  output logic                       expired_o,
  output logic                       nearing_expiry_o
);

  logic           prep_valid;
  logic           core_ready;
  drt_pkg::prep_t prep;

  drt_prep u_prep (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .now_time_i        (now_time_i),
    .ttl_seconds_i     (ttl_seconds_i),
    .key_matches_i     (key_matches_i),
    .same_rdata_i      (same_rdata_i),
    .jitter_permille_i (jitter_permille_i),
    .core_ready_i      (core_ready),
    .prep_valid_o      (prep_valid),
    .prep_o            (prep)
  );

  drt_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .prep_valid_i     (prep_valid),
    .prep_i           (prep),
    .core_ready_o     (core_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .send_query_o     (send_query_o),
    .expired_o        (expired_o),
    .nearing_expiry_o (nearing_expiry_o)
  );

`ifndef SYNTHESIS
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({send_query_o, expired_o, status_o != drt_pkg::ST_NONE}))
    else $error("more than one event kind in a result item");

  a_expired_not_nearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expired_o) |-> !nearing_expiry_o)
    else $error("dropped record reported as nearing expiry");

  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prep_valid && core_ready) |=> out_valid_o)
    else $error("processed item did not reach the result register");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (prep_valid && !core_ready))
    else $error("input stalled while the pipeline can advance");
`endif

endmodule
`default_nettype wire
